>>> hw/rtl/vra_pkg.sv
// Package for the variable ring allocator: widths, codes and defaults.
`timescale 1ns / 1ps
`default_nettype none

package vra_pkg;

   localparam int POOL_BYTES_DEF   = 4096;
   localparam int HEADER_BYTES_DEF = 1;

   localparam int SIZE_W   = 8;   // request / released size
   localparam int OFF_W    = 12;  // data_offset
   localparam int CNT_W    = 12;  // entry_count
   localparam int FREE_W   = 13;  // free_contiguous
   localparam int CSR_W    = 13;  // pool_bytes_used
   localparam int REQ_DW   = 8;
   localparam int REQ_UW   = 2;
   localparam int RSP_DW   = 48;
   localparam int RSP_UW   = 1;

   typedef enum logic [1:0] {
      OP_ALLOC   = 2'd0,
      OP_RELEASE = 2'd1,
      OP_PEEK    = 2'd2,
      OP_CLEAR   = 2'd3
   } vra_op_type;

   typedef enum logic [1:0] {
      STAT_OK   = 2'd0,
      STAT_OOM  = 2'd1,
      STAT_CRIT = 2'd2
   } vra_status_type;

   typedef enum logic {
      ST_IDLE,
      ST_EXEC
   } vra_state_type;

endpackage

`default_nettype wire

>>> hw/rtl/variable_ring_allocator_unit.sv
// Variable-length ring buffer allocator: top level with header memory and control.
`timescale 1ns / 1ps
`default_nettype none

// Manages a byte pool as a FIFO ring of entries, each a size header then data.
// req_* : one item per command; tuser = operation, tdata = request size.
// rsp_* : one result item per command, held in an output register until taken.
// csr_* : pool_bytes_used port, always ready; user must write only while idle (unchecked).
// Timing: an item is taken in the idle state and worked in the exec state,
//   so the block takes no new item until it has worked the last one;
//   rsp_tvalid rises from the output register once the work is done. The
//   exec state exists because release needs the oldest entry's header byte,
//   registered out of the header memory, whose read address always tracks the tail.
// While a result waits on rsp_tready the next item is still taken; its work
//   cycle then holds until the output register is free.
// Reset (synchronous, active high) clears head, tail, wrap point, entry count,
//   status and the output valid flag, and sets pool_bytes_used to the full pool.
//   The header memory is not cleared: a header is always written before read.
// A critical error (pointer overrun) locks the block, which then returns null
//   results and zero free space until a clear-ring command or reset.
module variable_ring_allocator_unit
   import vra_pkg::*;
#(
   parameter int POOL_BYTES   = POOL_BYTES_DEF,
   parameter int HEADER_BYTES = HEADER_BYTES_DEF
) (
   input  wire logic              clock,
   input  wire logic              reset,
   // command channel
   input  wire logic              req_tvalid,
   output logic                   req_tready,
   input  wire logic [REQ_DW-1:0] req_tdata,   // [7:0] request_size
   input  wire logic [REQ_UW-1:0] req_tuser,   // [1:0] operation
   // result channel
   output logic                   rsp_tvalid,
   input  wire logic              rsp_tready,
   output logic [RSP_DW-1:0]      rsp_tdata,   // [11:0] data_offset, [19:12] released_size,
                                               // [21:20] status, [33:22] entry_count,
                                               // [46:34] free_contiguous, [47] zero
   output logic [RSP_UW-1:0]      rsp_tuser,   // [0] offset_valid
   // pool size register
   input  wire logic              csr_valid,
   output logic                   csr_ready,
   input  wire logic [CSR_W-1:0]  csr_data
);

   localparam int AW    = (POOL_BYTES > 1) ? $clog2(POOL_BYTES) : 1;
   localparam int PW    = $clog2(POOL_BYTES + 1);          // pointer, holds pool size
   localparam int SW    = ((PW > SIZE_W + 1) ? PW : SIZE_W + 1) + 1; // arithmetic width
   localparam int CFG_W = (PW > CSR_W) ? PW : CSR_W;

   // ---------------- state ----------------
   vra_state_type  state_ff, state_in;
   logic [PW-1:0]  head_ff, head_in;
   logic [PW-1:0]  tail_ff, tail_in;
   logic [PW-1:0]  wrap_ff, wrap_in;
   logic [CNT_W-1:0] held_ff, held_in;
   vra_status_type err_ff, err_in;
   logic [CFG_W-1:0] cfg_ff;

   // accepted command
   vra_op_type        op_ff;
   logic [SIZE_W-1:0] rsize_ff;

   // output register
   logic              rsp_valid_ff, rsp_valid_in;
   logic [OFF_W-1:0]  out_off_ff, out_off_in;
   logic              out_ov_ff, out_ov_in;
   logic [SIZE_W-1:0] out_rel_ff, out_rel_in;
   logic [CNT_W-1:0]  out_cnt_ff;
   vra_status_type    out_st_ff;
   logic [FREE_W-1:0] out_free_ff;

   // header memory
   logic [SIZE_W-1:0] hdr_mem [POOL_BYTES];
   logic [SIZE_W-1:0] hdr_rd_ff;
   logic              wr_en;
   logic [AW-1:0]     wr_addr;

   // arithmetic
   logic [SW-1:0] size_s, head_s, tail_s, wrap_s;
   logic [SW-1:0] full_s, step_s, room_s, start_s, head_sum, tail_sum;
   logic [SW-1:0] free_now, free_next;
   logic          do_work;

   // largest contiguous free run for a given ring state
   function automatic logic [SW-1:0] free_run(
      input logic [SW-1:0] head,
      input logic [SW-1:0] tail,
      input logic [SW-1:0] wrap,
      input logic          crit,
      input logic [SW-1:0] size
   );
      logic [SW-1:0] after;
      logic [SW-1:0] res;
      after = (size > head) ? size - head : '0;
      if (crit) begin
         res = '0;
      end else if (head == tail) begin
         res = (wrap == '0) ? size : '0;
      end else if (wrap != '0) begin
         res = (tail > head) ? tail - head : '0;
      end else begin
         res = (after > tail) ? after : tail;
      end
      return res;
   endfunction

   // effective pool size, clamped to [2, POOL_BYTES]
   always_comb begin
      if (cfg_ff < CFG_W'(2)) begin
         size_s = SW'(2);
      end else if (cfg_ff > CFG_W'(POOL_BYTES)) begin
         size_s = SW'(POOL_BYTES);
      end else begin
         size_s = SW'(cfg_ff);
      end
   end

   assign head_s   = SW'(head_ff);
   assign tail_s   = SW'(tail_ff);
   assign wrap_s   = SW'(wrap_ff);
   assign full_s   = SW'(rsize_ff) + SW'(HEADER_BYTES);
   assign step_s   = SW'(hdr_rd_ff) + SW'(HEADER_BYTES);
   assign room_s   = (size_s > head_s) ? size_s - head_s : '0;
   assign start_s  = (room_s < full_s && tail_s <= head_s) ? '0 : head_s;
   assign head_sum = start_s + full_s;
   assign tail_sum = tail_s + step_s;
   assign free_now = free_run(head_s, tail_s, wrap_s, err_ff == STAT_CRIT, size_s);
   assign free_next = free_run(SW'(head_in), SW'(tail_in), SW'(wrap_in),
                               err_in == STAT_CRIT, size_s);

   assign do_work    = (state_ff == ST_EXEC) && (!rsp_valid_ff || rsp_tready);
   assign req_tready = (state_ff == ST_IDLE);
   assign csr_ready  = 1'b1;

   // next state and result
   always_comb begin
      state_in     = state_ff;
      head_in      = head_ff;
      tail_in      = tail_ff;
      wrap_in      = wrap_ff;
      held_in      = held_ff;
      err_in       = err_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      out_off_in   = '0;
      out_ov_in    = 1'b0;
      out_rel_in   = '0;
      wr_en        = 1'b0;
      wr_addr      = AW'(start_s);

      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (do_work) begin
               state_in     = ST_IDLE;
               rsp_valid_in = 1'b1;
               if (op_ff == OP_CLEAR) begin
                  head_in = '0;
                  tail_in = '0;
                  wrap_in = '0;
                  held_in = '0;
                  err_in  = STAT_OK;
               end else if (err_ff == STAT_CRIT) begin
                  // locked: null result
               end else begin
                  case (op_ff)
                     OP_ALLOC: begin
                        if (rsize_ff == '0) begin
                           err_in = STAT_OK;
                        end else if (free_now <= full_s) begin
                           err_in = STAT_OOM;
                        end else begin
                           // wrap to the pool start when the end is too short
                           if (room_s < full_s && tail_s < head_s) begin
                              wrap_in = head_ff;
                           end
                           if (room_s < full_s && tail_s == head_s) begin
                              tail_in = '0;
                           end
                           wr_en = 1'b1;
                           if (head_sum >= size_s) begin
                              head_in = '0;
                              tail_in = '0;
                              err_in  = STAT_CRIT;
                           end else begin
                              head_in    = PW'(head_sum);
                              held_in    = held_ff + CNT_W'(1);
                              err_in     = STAT_OK;
                              out_off_in = OFF_W'(start_s + SW'(HEADER_BYTES));
                              out_ov_in  = 1'b1;
                           end
                        end
                     end
                     OP_RELEASE: begin
                        if (head_s == tail_s) begin
                           err_in = STAT_OK;
                        end else if (wrap_s != '0 && tail_sum >= wrap_s) begin
                           tail_in    = '0;
                           wrap_in    = '0;
                           held_in    = held_ff - CNT_W'(1);
                           err_in     = STAT_OK;
                           out_rel_in = hdr_rd_ff;
                        end else if (tail_sum >= size_s) begin
                           head_in = '0;
                           tail_in = '0;
                           err_in  = STAT_CRIT;
                        end else begin
                           tail_in    = PW'(tail_sum);
                           held_in    = held_ff - CNT_W'(1);
                           err_in     = STAT_OK;
                           out_rel_in = hdr_rd_ff;
                        end
                     end
                     default: begin
                        // peek
                        if (head_s != tail_s) begin
                           out_off_in = OFF_W'(tail_s + SW'(HEADER_BYTES));
                           out_ov_in  = 1'b1;
                        end
                     end
                  endcase
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         head_ff      <= '0;
         tail_ff      <= '0;
         wrap_ff      <= '0;
         held_ff      <= '0;
         err_ff       <= STAT_OK;
         rsp_valid_ff <= 1'b0;
         cfg_ff       <= CFG_W'(POOL_BYTES);
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         wrap_ff      <= wrap_in;
         held_ff      <= held_in;
         err_ff       <= err_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid) begin
            cfg_ff <= CFG_W'(csr_data);
         end
      end
   end

   // command capture and result payload
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         op_ff    <= vra_op_type'(req_tuser);
         rsize_ff <= req_tdata[SIZE_W-1:0];
      end
      if (do_work) begin
         out_off_ff  <= out_off_in;
         out_ov_ff   <= out_ov_in;
         out_rel_ff  <= out_rel_in;
         out_st_ff   <= err_in;
         out_cnt_ff  <= held_in;
         out_free_ff <= FREE_W'(free_next);
      end
   end

   // header memory: write at the new entry, read follows the tail
   always_ff @(posedge clock) begin
      if (wr_en) begin
         hdr_mem[wr_addr] <= rsize_ff;
      end
      hdr_rd_ff <= hdr_mem[AW'(tail_ff)];
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, out_free_ff, out_cnt_ff, out_st_ff, out_rel_ff, out_off_ff};
   assign rsp_tuser  = out_ov_ff;

endmodule

`default_nettype wire
